### src/kdq_pkg.sv
`timescale 1ns / 1ps
// kdq_pkg: shared types and codes for the keyed deque table.
// No dependencies; imported by kdq_cell, kdq_max_node and keyed_deque_table.
package kdq_pkg;

  localparam int KEY_W    = 16;
  localparam int VAL_W    = 24;
  localparam int OP_W     = 3;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 5;

  localparam logic [OP_W-1:0] OP_PUSH_BACK  = 3'd0;
  localparam logic [OP_W-1:0] OP_PUSH_FRONT = 3'd1;
  localparam logic [OP_W-1:0] OP_POP_FRONT  = 3'd2;
  localparam logic [OP_W-1:0] OP_POP_BACK   = 3'd3;
  localparam logic [OP_W-1:0] OP_SEARCH     = 3'd4;
  localparam logic [OP_W-1:0] OP_UPDATE     = 3'd5;

  localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY     = 2'd1;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd2;
  localparam logic [STATUS_W-1:0] ST_FULL      = 2'd3;

  // shift controls shared by every cell of the row
  typedef struct packed {
    logic shift_r;
    logic shift_l;
  } cell_ctl_t;

  typedef struct packed {
    logic             valid;
    logic [KEY_W-1:0] key;
    logic [VAL_W-1:0] value;
  } max_node_t;

endpackage

### src/kdq_cell.sv
`timescale 1ns / 1ps
// kdq_cell: one slot of the deque row; holds a key/value and shifts with its neighbors.
// Depends on kdq_pkg.
module kdq_cell (
  input  logic                     clk,
  input  kdq_pkg::cell_ctl_t       ctl,
  input  logic                     load_entry,
  input  logic                     load_value,
  input  logic [kdq_pkg::KEY_W-1:0] item_key,
  input  logic [kdq_pkg::VAL_W-1:0] item_value,
  input  logic [kdq_pkg::KEY_W-1:0] left_key,
  input  logic [kdq_pkg::VAL_W-1:0] left_value,
  input  logic [kdq_pkg::KEY_W-1:0] right_key,
  input  logic [kdq_pkg::VAL_W-1:0] right_value,
  output logic [kdq_pkg::KEY_W-1:0] cell_key,
  output logic [kdq_pkg::VAL_W-1:0] cell_value,
  output logic                     hit
);
  import kdq_pkg::*;

  always_ff @(posedge clk) begin
    if (ctl.shift_r) begin
      cell_key   <= left_key;
      cell_value <= left_value;
    end else if (ctl.shift_l) begin
      cell_key   <= right_key;
      cell_value <= right_value;
    end else if (load_entry) begin
      cell_key   <= item_key;
      cell_value <= item_value;
    end else if (load_value) begin
      cell_value <= item_value;
    end
  end

  assign hit = (cell_key == item_key);

endmodule

### src/kdq_max_node.sv
`timescale 1ns / 1ps
// kdq_max_node: one registered node of the maximum tree; left side wins ties.
// Depends on kdq_pkg.
module kdq_max_node (
  input  logic               clk,
  input  logic               rst,
  input  kdq_pkg::max_node_t lhs,
  input  kdq_pkg::max_node_t rhs,
  output kdq_pkg::max_node_t best
);
  import kdq_pkg::*;

  logic take_lhs;

  assign take_lhs = lhs.valid && (!rhs.valid || (lhs.value >= rhs.value));

  always_ff @(posedge clk) begin
    if (rst) begin
      best.valid <= 1'b0;
    end else begin
      best.valid <= lhs.valid | rhs.valid;
    end
    best.key   <= take_lhs ? lhs.key : rhs.key;
    best.value <= take_lhs ? lhs.value : rhs.value;
  end

endmodule

### src/keyed_deque_table.sv
`timescale 1ns / 1ps
// keyed_deque_table: bounded deque of key/value words held in a row of shifting cells.
// A word is accepted in IDLE, applied to the cell row in EXEC and held in WAIT until the registered
// maximum tree has settled after that update; req_stall refuses a new word until the result word
// is loaded, so a word is not taken while another is in flight, and rsp_stall can hold WAIT.
// Reset: synchronous, clears count, control and output valid; cell contents are not cleared.
// Depends on kdq_pkg, kdq_cell, kdq_max_node.
module keyed_deque_table #(
  parameter int DEPTH = 16
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         req_valid,
  output logic                         req_stall,
  input  logic [kdq_pkg::OP_W-1:0]     op,
  input  logic [kdq_pkg::KEY_W-1:0]    item_key,
  input  logic [kdq_pkg::VAL_W-1:0]    item_value,
  output logic                         rsp_valid,
  input  logic                         rsp_stall,
  output logic [kdq_pkg::STATUS_W-1:0] status,
  output logic [kdq_pkg::KEY_W-1:0]    hit_key,
  output logic [kdq_pkg::VAL_W-1:0]    hit_value,
  output logic [kdq_pkg::COUNT_W-1:0]  entry_count,
  output logic                         max_valid,
  output logic [kdq_pkg::KEY_W-1:0]    max_key,
  output logic [kdq_pkg::VAL_W-1:0]    max_value
);
  import kdq_pkg::*;

  localparam int CW     = $clog2(DEPTH + 1);
  localparam int LEVELS = $clog2(DEPTH);
  localparam int LEAVES = 1 << LEVELS;
  localparam int WCW    = $clog2(LEVELS + 1);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EXEC = 2'd1;
  localparam logic [1:0] S_WAIT = 2'd2;

  logic [1:0]          state;
  logic [1:0]          state_next;
  logic [WCW-1:0]      wait_cnt;
  logic [CW-1:0]       count;
  logic [CW-1:0]       count_next;
  logic [OP_W-1:0]     op_q;
  logic [KEY_W-1:0]    key_q;
  logic [VAL_W-1:0]    value_q;
  logic [STATUS_W-1:0] res_status;
  logic [KEY_W-1:0]    res_key;
  logic [VAL_W-1:0]    res_value;
  logic [STATUS_W-1:0] res_status_next;
  logic [KEY_W-1:0]    res_key_next;
  logic [VAL_W-1:0]    res_value_next;

  logic                exec;
  logic                full;
  logic                empty;
  logic                out_load;
  cell_ctl_t           ctl;
  logic [DEPTH-1:0]    pos_valid;
  logic [DEPTH-1:0]    at_count;
  logic [DEPTH-1:0]    last_pos;
  logic [DEPTH-1:0]    cell_hit;
  logic [DEPTH-1:0]    match_v;
  logic [DEPTH-1:0]    first;
  logic [DEPTH-1:0]    load_entry;
  logic [DEPTH-1:0]    load_value;
  logic [KEY_W-1:0]    cell_key   [DEPTH];
  logic [VAL_W-1:0]    cell_value [DEPTH];
  logic [KEY_W-1:0]    first_key;
  logic [VAL_W-1:0]    first_value;
  logic [KEY_W-1:0]    last_key;
  logic [VAL_W-1:0]    last_value;
  max_node_t           tree [1:2*LEAVES-1];

  assign exec  = (state == S_EXEC);
  assign full  = (count == CW'(DEPTH));
  assign empty = (count == '0);

  assign req_stall = (state != S_IDLE);

  assign ctl.shift_r = exec && (op_q == OP_PUSH_FRONT) && !full;
  assign ctl.shift_l = exec && (op_q == OP_POP_FRONT) && !empty;

  assign match_v = pos_valid & cell_hit;
  assign first   = match_v & (~match_v + 1'b1);

  genvar gi;
  generate
    for (gi = 0; gi < DEPTH; gi++) begin : g_cell
      logic [KEY_W-1:0] lk;
      logic [VAL_W-1:0] lv;
      logic [KEY_W-1:0] rk;
      logic [VAL_W-1:0] rv;

      assign pos_valid[gi]  = (CW'(gi) < count);
      assign at_count[gi]   = (CW'(gi) == count);
      assign load_entry[gi] = exec && (op_q == OP_PUSH_BACK) && !full && at_count[gi];
      assign load_value[gi] = exec && (op_q == OP_UPDATE) && first[gi];

      if (gi == 0) begin : g_head
        assign lk = key_q;
        assign lv = value_q;
      end else begin : g_body
        assign lk = cell_key[gi-1];
        assign lv = cell_value[gi-1];
      end

      if (gi == DEPTH - 1) begin : g_tail
        assign rk = cell_key[gi];
        assign rv = cell_value[gi];
        assign last_pos[gi] = pos_valid[gi];
      end else begin : g_mid
        assign rk = cell_key[gi+1];
        assign rv = cell_value[gi+1];
        assign last_pos[gi] = pos_valid[gi] & ~pos_valid[gi+1];
      end

      kdq_cell u_cell (
        .clk        (clk),
        .ctl        (ctl),
        .load_entry (load_entry[gi]),
        .load_value (load_value[gi]),
        .item_key   (key_q),
        .item_value (value_q),
        .left_key   (lk),
        .left_value (lv),
        .right_key  (rk),
        .right_value(rv),
        .cell_key   (cell_key[gi]),
        .cell_value (cell_value[gi]),
        .hit        (cell_hit[gi])
      );
    end

    // leaves in front-to-back order, padded with empty nodes
    for (gi = 0; gi < LEAVES; gi++) begin : g_leaf
      if (gi < DEPTH) begin : g_used
        assign tree[LEAVES+gi] = '{valid: pos_valid[gi], key: cell_key[gi],
                                   value: cell_value[gi]};
      end else begin : g_pad
        assign tree[LEAVES+gi] = '0;
      end
    end

    for (gi = 1; gi < LEAVES; gi++) begin : g_node
      kdq_max_node u_node (
        .clk (clk),
        .rst (rst),
        .lhs (tree[2*gi]),
        .rhs (tree[2*gi+1]),
        .best(tree[gi])
      );
    end
  endgenerate

  always_comb begin
    first_key   = '0;
    first_value = '0;
    last_key    = '0;
    last_value  = '0;
    for (int i = 0; i < DEPTH; i++) begin
      first_key   = first_key   | ({KEY_W{first[i]}} & cell_key[i]);
      first_value = first_value | ({VAL_W{first[i]}} & cell_value[i]);
      last_key    = last_key    | ({KEY_W{last_pos[i]}} & cell_key[i]);
      last_value  = last_value  | ({VAL_W{last_pos[i]}} & cell_value[i]);
    end
  end

  always_comb begin
    res_status_next = ST_OK;
    res_key_next    = '0;
    res_value_next  = '0;
    count_next      = count;
    unique case (op_q)
      OP_PUSH_BACK, OP_PUSH_FRONT: begin
        if (full) begin
          res_status_next = ST_FULL;
        end else begin
          count_next = count + 1'b1;
        end
      end
      OP_POP_FRONT: begin
        if (empty) begin
          res_status_next = ST_EMPTY;
        end else begin
          res_key_next   = cell_key[0];
          res_value_next = cell_value[0];
          count_next     = count - 1'b1;
        end
      end
      OP_POP_BACK: begin
        if (empty) begin
          res_status_next = ST_EMPTY;
        end else begin
          res_key_next   = last_key;
          res_value_next = last_value;
          count_next     = count - 1'b1;
        end
      end
      OP_SEARCH, OP_UPDATE: begin
        if (match_v == '0) begin
          res_status_next = ST_NOT_FOUND;
        end else begin
          res_key_next   = first_key;
          res_value_next = (op_q == OP_UPDATE) ? value_q : first_value;
        end
      end
      default: begin
      end
    endcase
  end

  assign out_load = (state == S_WAIT) && (wait_cnt == '0) && (!rsp_valid || !rsp_stall);

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:  if (req_valid) state_next = S_EXEC;
      S_EXEC:  state_next = S_WAIT;
      S_WAIT:  if (out_load) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      wait_cnt  <= '0;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (exec) begin
        count    <= count_next;
        wait_cnt <= WCW'(LEVELS);
      end else if ((state == S_WAIT) && (wait_cnt != '0)) begin
        wait_cnt <= wait_cnt - 1'b1;
      end
      if (out_load) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if ((state == S_IDLE) && req_valid) begin
      op_q    <= op;
      key_q   <= item_key;
      value_q <= item_value;
    end
    if (exec) begin
      res_status <= res_status_next;
      res_key    <= res_key_next;
      res_value  <= res_value_next;
    end
    if (out_load) begin
      status      <= res_status;
      hit_key     <= res_key;
      hit_value   <= res_value;
      entry_count <= COUNT_W'(count);
      max_valid   <= tree[1].valid;
      max_key     <= tree[1].valid ? tree[1].key : '0;
      max_value   <= tree[1].valid ? tree[1].value : '0;
    end
  end

  a_full_push_holds: assert property (@(posedge clk) disable iff (rst)
    (exec && full && ((op_q == OP_PUSH_BACK) || (op_q == OP_PUSH_FRONT)))
      |=> $stable(count))
    else $error("refused push changed the count");

  a_pop_decrements: assert property (@(posedge clk) disable iff (rst)
    (exec && !empty && ((op_q == OP_POP_FRONT) || (op_q == OP_POP_BACK)))
      |=> (count == $past(count) - 1'b1))
    else $error("pop did not decrement the count");

  a_rsp_from_wait: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp_valid) |-> ($past(state) == S_WAIT))
    else $error("result word raised outside the wait state");

  a_max_tracks_count: assert property (@(posedge clk) disable iff (rst)
    out_load |=> (max_valid == (count != '0)))
    else $error("maximum valid disagrees with the entry count");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    exec |=> (count <= CW'(DEPTH)))
    else $error("entry count above depth");

endmodule
